>>> hw/rtl/lstk_pkg.sv
package lstk_pkg;

  // stack geometry
  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int KIND_W = 3;
  localparam int ERR_W  = 3;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);

  // operation codes carried by an input word
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH  = 3'd0,
    KIND_PRINT = 3'd1,
    KIND_PEEK  = 3'd2,
    KIND_POP   = 3'd3,
    KIND_SWAP  = 3'd4
  } kind_t;

  // error codes carried by an output word
  typedef enum logic [ERR_W-1:0] {
    ERR_NONE       = 3'd0,
    ERR_PEEK_EMPTY = 3'd1,
    ERR_POP_EMPTY  = 3'd2,
    ERR_SWAP_SHORT = 3'd3,
    ERR_PUSH_FULL  = 3'd4
  } error_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PEEK,
    ST_SWAP_RD,
    ST_SWAP_WR,
    ST_SWAP_FIN,
    ST_PRINT_RD,
    ST_OUT
  } state_t;

  // read address choice
  typedef enum logic [1:0] {
    RD_TOP,
    RD_SECOND,
    RD_NEXT
  } rd_sel_t;

  // write address and data choice
  typedef enum logic [1:0] {
    WR_PUSH,
    WR_SWAP_TOP,
    WR_SWAP_LOW
  } wr_sel_t;

  // controller to datapath
  typedef struct packed {
    logic    cnt_inc;
    logic    cnt_dec;
    logic    re;
    rd_sel_t rd_sel;
    logic    cursor_load;
    logic    cursor_dec;
    logic    tmp_load;
    logic    we;
    wr_sel_t wr_sel;
    logic    out_load;
    error_t  out_err;
    logic    out_from_ram;
    logic    out_last_cursor;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic short_stack;
    logic full;
    logic out_last;
  } status_t;

endpackage

>>> hw/rtl/lifo_stack_push_pop_swap.sv
// push and pop finish in the accepting cycle; the next word can be taken in the following cycle
// peek words pass a ram read, error words are registered at accept; both held until taken
// swap does two ram reads and two ram writes through one port each
// print all reads each entry from ram, then outputs it, waiting while the output stalls
// one word in flight at a time; input stall is high until the word ends (last output taken)
// reset (rst, synchronous) empties the stack; the storage ram is not cleared
module lifo_stack_push_pop_swap import lstk_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [KIND_W-1:0]        kind,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] data,
  output logic [ERR_W-1:0]         error,
  output logic                     last
);

  cmd_t    cmd;
  status_t status;

  lstk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .kind      (kind),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  lstk_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .value  (value),
    .status (status),
    .data   (data),
    .error  (error),
    .last   (last)
  );

endmodule

>>> hw/rtl/lstk_ram.sv
module lstk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/lstk_ctrl.sv
module lstk_ctrl import lstk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [KIND_W-1:0] kind,
  input  logic        out_stall,
  input  status_t     status,
  output logic        in_stall,
  output logic        out_valid,
  output cmd_t        cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = in_valid && (state == ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_PUSH:  if (status.full) state_next = ST_OUT;
            KIND_PRINT: if (!status.empty) state_next = ST_PRINT_RD;
            KIND_PEEK:  state_next = status.empty ? ST_OUT : ST_PEEK;
            KIND_POP:   if (status.empty) state_next = ST_OUT;
            KIND_SWAP:  state_next = status.short_stack ? ST_OUT : ST_SWAP_RD;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_PEEK:     state_next = ST_OUT;
      ST_SWAP_RD:  state_next = ST_SWAP_WR;
      ST_SWAP_WR:  state_next = ST_SWAP_FIN;
      ST_SWAP_FIN: state_next = ST_IDLE;
      ST_PRINT_RD: state_next = ST_OUT;
      ST_OUT: begin
        if (!out_stall) begin
          state_next = status.out_last ? ST_IDLE : ST_PRINT_RD;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // commands and handshake outputs
  always_comb begin
    cmd             = '0;
    cmd.rd_sel      = RD_TOP;
    cmd.wr_sel      = WR_PUSH;
    cmd.out_err     = ERR_NONE;
    in_stall        = (state != ST_IDLE);
    out_valid       = (state == ST_OUT);
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_PUSH: begin
              if (status.full) begin
                cmd.out_load = 1'b1;
                cmd.out_err  = ERR_PUSH_FULL;
              end else begin
                cmd.we      = 1'b1;
                cmd.wr_sel  = WR_PUSH;
                cmd.cnt_inc = 1'b1;
              end
            end
            KIND_PRINT: begin
              if (!status.empty) begin
                cmd.re          = 1'b1;
                cmd.rd_sel      = RD_TOP;
                cmd.cursor_load = 1'b1;
              end
            end
            KIND_PEEK: begin
              if (status.empty) begin
                cmd.out_load = 1'b1;
                cmd.out_err  = ERR_PEEK_EMPTY;
              end else begin
                cmd.re     = 1'b1;
                cmd.rd_sel = RD_TOP;
              end
            end
            KIND_POP: begin
              if (status.empty) begin
                cmd.out_load = 1'b1;
                cmd.out_err  = ERR_POP_EMPTY;
              end else begin
                cmd.cnt_dec = 1'b1;
              end
            end
            KIND_SWAP: begin
              if (status.short_stack) begin
                cmd.out_load = 1'b1;
                cmd.out_err  = ERR_SWAP_SHORT;
              end else begin
                cmd.re     = 1'b1;
                cmd.rd_sel = RD_TOP;
              end
            end
            default: begin
              cmd.re = 1'b0;
            end
          endcase
        end
      end
      ST_PEEK: begin
        cmd.out_load     = 1'b1;
        cmd.out_from_ram = 1'b1;
      end
      ST_SWAP_RD: begin
        cmd.tmp_load = 1'b1;
        cmd.re       = 1'b1;
        cmd.rd_sel   = RD_SECOND;
      end
      ST_SWAP_WR: begin
        cmd.we     = 1'b1;
        cmd.wr_sel = WR_SWAP_TOP;
      end
      ST_SWAP_FIN: begin
        cmd.we     = 1'b1;
        cmd.wr_sel = WR_SWAP_LOW;
      end
      ST_PRINT_RD: begin
        cmd.out_load        = 1'b1;
        cmd.out_from_ram    = 1'b1;
        cmd.out_last_cursor = 1'b1;
      end
      ST_OUT: begin
        if (!out_stall && !status.out_last) begin
          cmd.cursor_dec = 1'b1;
          cmd.re         = 1'b1;
          cmd.rd_sel     = RD_NEXT;
        end
      end
      default: begin
        cmd.re = 1'b0;
      end
    endcase
  end

endmodule

>>> hw/rtl/lstk_dp.sv
module lstk_dp import lstk_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  input  logic signed [DATA_W-1:0] value,
  output status_t                  status,
  output logic signed [DATA_W-1:0] data,
  output logic [ERR_W-1:0]         error,
  output logic                     last
);

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  logic [ADDR_W-1:0] cursor;
  logic [ADDR_W-1:0] cursor_m1;
  logic [DATA_W-1:0] tmp;
  logic [DATA_W-1:0] rdata;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] data_q;
  error_t            error_q;
  logic              last_q;

  assign cnt_m1    = count - CNT_W'(1);
  assign cnt_m2    = count - CNT_W'(2);
  assign cursor_m1 = cursor - ADDR_W'(1);

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      RD_TOP:    raddr = cnt_m1[ADDR_W-1:0];
      RD_SECOND: raddr = cnt_m2[ADDR_W-1:0];
      RD_NEXT:   raddr = cursor_m1;
      default:   raddr = cnt_m1[ADDR_W-1:0];
    endcase
  end

  // write address and data select
  always_comb begin
    case (cmd.wr_sel)
      WR_PUSH: begin
        waddr = count[ADDR_W-1:0];
        wdata = value;
      end
      WR_SWAP_TOP: begin
        waddr = cnt_m1[ADDR_W-1:0];
        wdata = rdata;
      end
      WR_SWAP_LOW: begin
        waddr = cnt_m2[ADDR_W-1:0];
        wdata = tmp;
      end
      default: begin
        waddr = count[ADDR_W-1:0];
        wdata = value;
      end
    endcase
  end

  lstk_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count <= cnt_m1;
    end
  end

  // print cursor and swap holding register
  always_ff @(posedge clk) begin
    if (cmd.cursor_load) begin
      cursor <= cnt_m1[ADDR_W-1:0];
    end else if (cmd.cursor_dec) begin
      cursor <= cursor_m1;
    end
    if (cmd.tmp_load) begin
      tmp <= rdata;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      data_q  <= cmd.out_from_ram ? rdata : '0;
      error_q <= cmd.out_err;
      last_q  <= cmd.out_last_cursor ? (cursor == '0) : 1'b1;
    end
  end

  assign status.empty       = (count == '0);
  assign status.short_stack = (count < CNT_W'(2));
  assign status.full        = (count == CNT_W'(DEPTH));
  assign status.out_last    = last_q;

  assign data  = data_q;
  assign error = error_q;
  assign last  = last_q;

endmodule

>>> hw/rtl/lstk_checker.sv
module lstk_checker import lstk_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [KIND_W-1:0]        kind,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] data,
  input logic [ERR_W-1:0]         error,
  input logic                     last
);

  // a stalled output word holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data) && $stable(error) && $stable(last))
    else $error("output word changed while stalled");

  // no new word is taken while a result is pending
  assert property (@(posedge clk) out_valid |-> in_stall)
    else $error("input open while output pending");

  // error words are single, final and carry zero data
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (error != ERR_NONE) |-> last && (data == '0))
    else $error("malformed error word");

  // reset leaves the block idle and ready
  assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  // undefined operation codes give no output
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (kind > KIND_W'(KIND_SWAP)) |=> !out_valid && !in_stall)
    else $error("output after undefined operation");

endmodule

bind lifo_stack_push_pop_swap lstk_checker u_lstk_checker (.*);

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lstk_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_SHOWN = 40;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    error_t                   err;
    logic                     last;
  } out_word_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [KIND_W-1:0]        kind = KIND_PUSH;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] data;
  logic [ERR_W-1:0]         error;
  logic                     last;

  // shadow copy of the stack and the words still owed by the block
  logic signed [DATA_W-1:0] stack_img [DEPTH];
  int                       stack_fill = 0;
  out_word_t                owed_words[$];
  out_word_t                want;
  int                       fail_cnt = 0;
  int                       cycle_cnt = 0;
  int                       burst_left = 0;
  int                       stall_mode = 0;

  lifo_stack_push_pop_swap dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .value    (value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .data     (data),
    .error    (error),
    .last     (last)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("lifo_stack_push_pop_swap regression: fail");
      $finish;
    end
  end

  // output stall pattern in one of four modes, each drawn at random
  always @(posedge clk) begin
    if (cycle_cnt % 50 == 0) begin
      stall_mode = $urandom_range(0, 3);
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= $urandom_range(0, 1);
      default: out_stall <= ((cycle_cnt % 8) < 5);
    endcase
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    if (fail_cnt < MAX_SHOWN) begin
      $display("mismatch at cycle %0d: %s got %0h wanted %0h", cycle_cnt, what, got,
               exp_val);
    end
    fail_cnt++;
  endtask

  // compare each accepted output word with the oldest owed word
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (owed_words.size() == 0) begin
        report_mismatch("unexpected word, data", data, '0);
      end else begin
        want = owed_words.pop_front();
        if (data !== want.data) report_mismatch("data", data, want.data);
        if (error !== want.err) report_mismatch("error", 32'(error), 32'(want.err));
        if (last !== want.last) report_mismatch("last", 32'(last), 32'(want.last));
      end
    end
  end

  task automatic owe_word(input logic signed [DATA_W-1:0] d, input error_t e,
                          input logic l);
    out_word_t w;
    w.data = d;
    w.err  = e;
    w.last = l;
    owed_words.push_back(w);
  endtask

  // apply one accepted word to the shadow stack
  task automatic apply_to_stack(input logic [KIND_W-1:0] k,
                                input logic signed [DATA_W-1:0] v);
    logic signed [DATA_W-1:0] t;
    case (k)
      KIND_PUSH: begin
        if (stack_fill >= DEPTH) begin
          owe_word('0, ERR_PUSH_FULL, 1'b1);
        end else begin
          stack_img[stack_fill] = v;
          stack_fill++;
        end
      end
      KIND_PRINT: begin
        for (int i = stack_fill; i > 0; i--) begin
          owe_word(stack_img[i-1], ERR_NONE, i == 1);
        end
      end
      KIND_PEEK: begin
        if (stack_fill == 0) owe_word('0, ERR_PEEK_EMPTY, 1'b1);
        else owe_word(stack_img[stack_fill-1], ERR_NONE, 1'b1);
      end
      KIND_POP: begin
        if (stack_fill == 0) owe_word('0, ERR_POP_EMPTY, 1'b1);
        else stack_fill--;
      end
      KIND_SWAP: begin
        if (stack_fill < 2) begin
          owe_word('0, ERR_SWAP_SHORT, 1'b1);
        end else begin
          t = stack_img[stack_fill-1];
          stack_img[stack_fill-1] = stack_img[stack_fill-2];
          stack_img[stack_fill-2] = t;
        end
      end
      default: ;
    endcase
  endtask

  // send one word: bursts of random length with random gaps in between
  task automatic send_word(input logic [KIND_W-1:0] k, input logic signed [DATA_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    kind     <= k;
    value    <= v;
    do @(posedge clk); while (in_stall !== 1'b0);
    apply_to_stack(k, v);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  // weighted operation choice; push_pct and pop_pct steer the stack depth
  function automatic logic [KIND_W-1:0] pick_kind(input int push_pct, input int pop_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) return KIND_PUSH;
    r -= push_pct;
    if (r < pop_pct) return KIND_POP;
    case ($urandom_range(0, 9))
      0, 1, 2: return KIND_SWAP;
      3, 4, 5: return KIND_PEEK;
      6, 7:    return KIND_PRINT;
      default: return KIND_W'($urandom_range(int'(KIND_SWAP) + 1, (1 << KIND_W) - 1));
    endcase
  endfunction

  // errors and corner cases on an empty or one-entry stack
  task automatic test_empty_stack();
    send_word(KIND_PEEK, pick_value());
    send_word(KIND_POP, pick_value());
    send_word(KIND_SWAP, pick_value());
    send_word(KIND_PRINT, pick_value());
    for (int k = int'(KIND_SWAP) + 1; k < (1 << KIND_W); k++) begin
      send_word(KIND_W'(k), pick_value());
    end
    send_word(KIND_PUSH, 32'sh1234_5678);
    send_word(KIND_SWAP, '0);
    send_word(KIND_POP, '0);
    send_word(KIND_POP, '0);
  endtask

  // extreme values through push, swap, peek, print and pop
  task automatic test_value_extremes();
    send_word(KIND_PUSH, 32'sh8000_0000);
    send_word(KIND_PUSH, 32'sh7fff_ffff);
    send_word(KIND_PUSH, '0);
    send_word(KIND_PUSH, -1);
    send_word(KIND_PUSH, 32'shaaaa_aaaa);
    send_word(KIND_PUSH, 32'sh5555_5555);
    send_word(KIND_PEEK, '0);
    send_word(KIND_SWAP, '0);
    send_word(KIND_PEEK, '0);
    send_word(KIND_PRINT, '0);
    send_word(KIND_POP, '0);
    send_word(KIND_POP, '0);
    send_word(KIND_PEEK, '0);
  endtask

  // random mix at shallow depth
  task automatic test_random_ops(input int n);
    for (int i = 0; i < n; i++) begin
      send_word(pick_kind(40, 25), pick_value());
    end
  endtask

  // fill to the top, overflow, print the whole stack, then work around full
  task automatic test_full_stack(input int n);
    while (stack_fill < DEPTH) begin
      send_word(KIND_PUSH, pick_value());
    end
    send_word(KIND_PUSH, pick_value());
    send_word(KIND_PRINT, '0);
    for (int i = 0; i < n; i++) begin
      send_word(pick_kind(50, 35), pick_value());
    end
    send_word(KIND_PRINT, '0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_stack();
    test_value_extremes();
    test_random_ops(15);
    test_full_stack(5);
    test_random_ops(5);
    in_valid <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("lifo_stack_push_pop_swap regression: pass");
    end else begin
      $display("lifo_stack_push_pop_swap regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/lstk_pkg.sv
hw/rtl/lstk_ram.sv
hw/rtl/lstk_ctrl.sv
hw/rtl/lstk_dp.sv
hw/rtl/lifo_stack_push_pop_swap.sv
hw/rtl/lstk_checker.sv
tb/tb.sv
